[rtl/mfq_pkg.sv]
// shared types and constants of the multilevel feedback queue scheduler
package mfq_pkg;

  localparam int SLOTS_DEF  = 32;
  localparam int LEVELS_DEF = 5;

  localparam int BASE_W      = 10;
  localparam int NEED_W      = 16;
  localparam int CLK_W       = 32;
  localparam int STATUS_W    = 3;
  localparam int JOB_SLOT_W  = 5;
  localparam int LEVEL_OUT_W = 3;
  localparam int GRANT_W     = 14;

  // widest slot index and level index that the parameter ranges allow
  localparam int SLOT_MAX_W = 8;
  localparam int LV_MAX_W   = 3;

  localparam logic [BASE_W-1:0] BASE_RESET = 10'd10;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEPTED = 3'd0,
    STAT_REJECTED = 3'd1,
    STAT_IDLE     = 3'd2,
    STAT_DEMOTED  = 3'd3,
    STAT_FINISHED = 3'd4,
    STAT_RETIRED  = 3'd5
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic [JOB_SLOT_W-1:0]    job_slot;
    logic [LEVEL_OUT_W-1:0]   run_level;
    logic [GRANT_W-1:0]       granted_slice;
    logic [LEVEL_OUT_W-1:0]   next_level;
    logic [CLK_W-1:0]         wait_time;
  } result_t;

  typedef struct packed {
    logic [NEED_W-1:0] needed;
    logic [NEED_W-1:0] used;
    logic [CLK_W-1:0]  stamp;
  } job_t;

  // requests from the sequencer to the level queues
  typedef struct packed {
    logic                  pop;
    logic [LV_MAX_W-1:0]   pop_lv;
    logic                  push;
    logic [LV_MAX_W-1:0]   push_lv;
    logic [SLOT_MAX_W-1:0] push_slot;
  } qcmd_t;

endpackage

[rtl/mfq_if.sv]
// valid/ready channel interfaces for arrival/dispatch items and results
interface mfq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [mfq_pkg::NEED_W-1:0]  needed_time;

  modport source (output valid, output mode, output needed_time, input ready);
  modport sink   (input valid, input mode, input needed_time, output ready);
endinterface

interface mfq_out_if;
  logic                             valid;
  logic                             ready;
  logic [mfq_pkg::STATUS_W-1:0]     status;
  logic [mfq_pkg::JOB_SLOT_W-1:0]   job_slot;
  logic [mfq_pkg::LEVEL_OUT_W-1:0]  run_level;
  logic [mfq_pkg::GRANT_W-1:0]      granted_slice;
  logic [mfq_pkg::LEVEL_OUT_W-1:0]  next_level;
  logic [mfq_pkg::CLK_W-1:0]        wait_time;

  modport source (output valid, output status, output job_slot, output run_level,
                  output granted_slice, output next_level, output wait_time,
                  input ready);
  modport sink   (input valid, input status, input job_slot, input run_level,
                  input granted_slice, input next_level, input wait_time,
                  output ready);
endinterface

[rtl/mfq_alu.sv]
// shared 32-bit add/subtract unit with carry out
module mfq_alu (
  input  logic [mfq_pkg::CLK_W-1:0] a,
  input  logic [mfq_pkg::CLK_W-1:0] b,
  input  logic                      sub,
  output logic [mfq_pkg::CLK_W:0]   res
);

  logic [mfq_pkg::CLK_W-1:0] b_op;

  // carry out set on a subtract means a >= b
  assign b_op = sub ? ~b : b;
  assign res  = {1'b0, a} + {1'b0, b_op} + {{mfq_pkg::CLK_W{1'b0}}, sub};

endmodule

[rtl/mfq_queues.sv]
// per-level ring queues of slot indexes in one shared memory
module mfq_queues #(
  parameter int SLOTS  = mfq_pkg::SLOTS_DEF,
  parameter int LEVELS = mfq_pkg::LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mfq_pkg::qcmd_t             cmd,
  output logic [LEVELS-1:0]          nonempty,
  output logic [$clog2(SLOTS)-1:0]   rd_slot
);

  localparam int PTR_W  = $clog2(SLOTS);
  localparam int LV_W   = $clog2(LEVELS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int DEPTH  = LEVELS * SLOTS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [PTR_W-1:0] head_r [LEVELS];
  logic [PTR_W-1:0] head_nxt [LEVELS];
  logic [PTR_W-1:0] tail_r [LEVELS];
  logic [PTR_W-1:0] tail_nxt [LEVELS];
  logic [CNT_W-1:0] cnt_r [LEVELS];
  logic [CNT_W-1:0] cnt_nxt [LEVELS];

  logic [PTR_W-1:0] fifo_mem [DEPTH];
  logic [PTR_W-1:0] rd_slot_r;

  logic [LV_W-1:0]   pop_lv;
  logic [LV_W-1:0]   push_lv;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(SLOTS - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop_lv  = cmd.pop_lv[LV_W-1:0];
  assign push_lv = cmd.push_lv[LV_W-1:0];
  assign raddr   = ADDR_W'(pop_lv) * ADDR_W'(SLOTS) + ADDR_W'(head_r[pop_lv]);
  assign waddr   = ADDR_W'(push_lv) * ADDR_W'(SLOTS) + ADDR_W'(tail_r[push_lv]);

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      head_nxt[l] = head_r[l];
      tail_nxt[l] = tail_r[l];
      cnt_nxt[l]  = cnt_r[l];
      if (cmd.pop && (pop_lv == LV_W'(l))) begin
        head_nxt[l] = ptr_inc(head_r[l]);
        cnt_nxt[l]  = cnt_r[l] - CNT_W'(1);
      end
      if (cmd.push && (push_lv == LV_W'(l)) && (cnt_r[l] != CNT_W'(SLOTS))) begin
        tail_nxt[l] = ptr_inc(tail_r[l]);
        cnt_nxt[l]  = cnt_nxt[l] + CNT_W'(1);
      end
      nonempty[l] = (cnt_r[l] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= head_nxt[l];
        tail_r[l] <= tail_nxt[l];
        cnt_r[l]  <= cnt_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      fifo_mem[waddr] <= cmd.push_slot[PTR_W-1:0];
    end
    if (cmd.pop) begin
      rd_slot_r <= fifo_mem[raddr];
    end
  end

  assign rd_slot = rd_slot_r;

endmodule

[rtl/multilevel_feedback_queue_scheduler_unit.sv]
// top level of the multilevel feedback queue scheduler
//
// in_if carries one item per handshake: mode 0 is an arrival with its
// needed_time, mode 1 asks for one time slice to be dispatched. out_if returns
// exactly one result item per input item, in order. cfg_we/cfg_wdata write
// base_slice; write it only while the block is idle.
// A small sequencer drives one shared 32-bit add/subtract unit, so one item is
// worked on at a time and in_if.ready is high only while the sequencer waits.
// Arrival: the busy map is scanned eight slots a cycle, lowest chunk first,
// until a free slot is found or the last chunk is done.
// Dispatch: queue pop, slot table read, then used, clock and compare steps
// on the shared unit give the result, with two more subtracts for the wait time
// of a finished job; with every level empty the result is idle. The next item
// is taken the cycle after the result is handed to the output register.
// The output register holds a result until out_if.ready; a new item is still
// accepted meanwhile, and the sequencer only waits if a second result is done
// before the first is taken.
// Reset (synchronous, rst_n low) empties all levels, frees all slots, zeroes
// the elapsed clock and sets base_slice to 10; the slot table and queue
// memories are not cleared and need no clearing pass.
module multilevel_feedback_queue_scheduler_unit #(
  parameter int SLOTS  = mfq_pkg::SLOTS_DEF,
  parameter int LEVELS = mfq_pkg::LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mfq_in_if.sink                      in_if,
  mfq_out_if.source                   out_if,
  input  logic                        cfg_we,
  input  logic [mfq_pkg::BASE_W-1:0]  cfg_wdata
);

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LV_W    = $clog2(LEVELS);
  localparam int SLICE_W = mfq_pkg::BASE_W + LEVELS - 1;
  localparam int NCHUNK  = (SLOTS + 7) / 8;
  localparam int CH_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD     = NCHUNK * 8;
  localparam int CW      = mfq_pkg::CLK_W;
  localparam int NW      = mfq_pkg::NEED_W;

  // one-hot sequencer
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_SCAN  = 10'b0000000010,
    ST_DPOP  = 10'b0000000100,
    ST_DJRD  = 10'b0000001000,
    ST_DUSED = 10'b0000010000,
    ST_DCLK  = 10'b0000100000,
    ST_DCMP  = 10'b0001000000,
    ST_DSUB1 = 10'b0010000000,
    ST_DSUB2 = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [mfq_pkg::BASE_W-1:0]   base_r, base_nxt;
  logic [SLOTS-1:0]             busy_r, busy_nxt;
  logic [CW-1:0]                elapsed_r, elapsed_nxt;
  logic [CH_W-1:0]              scan_r, scan_nxt;
  logic [NW-1:0]                need_r, need_nxt;
  logic [LV_W-1:0]              lv_r, lv_nxt;
  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic [SLICE_W-1:0]           slice_r, slice_nxt;
  logic [NW-1:0]                used_r, used_nxt;
  mfq_pkg::result_t             res_r, res_nxt;
  mfq_pkg::result_t             out_pay_r, out_pay_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // slot table
  mfq_pkg::job_t                job_mem [SLOTS];
  mfq_pkg::job_t                job_rd_r;
  mfq_pkg::job_t                job_wdata;
  logic                         job_we;
  logic                         job_re;
  logic [SLOT_W-1:0]            job_waddr;
  logic [SLOT_W-1:0]            job_raddr;

  // queues
  mfq_pkg::qcmd_t               qcmd;
  logic [LEVELS-1:0]            q_nonempty;
  logic [SLOT_W-1:0]            q_rd_slot;

  // shared unit
  logic [CW-1:0]                alu_a;
  logic [CW-1:0]                alu_b;
  logic                         alu_sub;
  logic [CW:0]                  alu_res;

  // lowest free slot in the current chunk of eight
  logic [PAD-1:0]               free_pad;
  logic [7:0]                   chunk;
  logic [2:0]                   chunk_pos;
  logic                         chunk_found;
  logic [SLOT_W-1:0]            free_slot;
  logic                         scan_last;

  // lowest non-empty level
  logic [LV_W-1:0]              lv_pick;
  logic                         any_queued;

  logic                         out_free;
  logic [NW-1:0]                used_sum;

  mfq_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  mfq_queues #(
    .SLOTS  (SLOTS),
    .LEVELS (LEVELS)
  ) u_queues (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (qcmd),
    .nonempty (q_nonempty),
    .rd_slot  (q_rd_slot)
  );

  always_comb begin
    for (int i = 0; i < PAD; i++) begin
      free_pad[i] = (i < SLOTS) ? ~busy_r[i] : 1'b0;
    end
    chunk       = free_pad[{scan_r, 3'b000} +: 8];
    chunk_found = |chunk;
    chunk_pos   = '0;
    for (int i = 7; i >= 0; i--) begin
      if (chunk[i]) begin
        chunk_pos = 3'(i);
      end
    end
    free_slot = SLOT_W'({scan_r, chunk_pos});
    scan_last = (scan_r == CH_W'(NCHUNK - 1));

    lv_pick    = '0;
    any_queued = |q_nonempty;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (q_nonempty[l]) begin
        lv_pick = LV_W'(l);
      end
    end
  end

  // saturating used time from the shared unit
  assign used_sum = (alu_res[CW-1:NW] != '0) ? {NW{1'b1}} : alu_res[NW-1:0];
  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt   = state_r;
    base_nxt    = cfg_we ? cfg_wdata : base_r;
    busy_nxt    = busy_r;
    elapsed_nxt = elapsed_r;
    scan_nxt    = scan_r;
    need_nxt    = need_r;
    lv_nxt      = lv_r;
    slot_nxt    = slot_r;
    slice_nxt   = slice_r;
    used_nxt    = used_r;
    res_nxt     = res_r;

    out_pay_nxt   = out_pay_r;
    out_valid_nxt = out_valid_r && !out_if.ready;

    job_we    = 1'b0;
    job_re    = 1'b0;
    job_waddr = slot_r;
    job_raddr = q_rd_slot;
    job_wdata = '{needed: job_rd_r.needed, used: used_r, stamp: job_rd_r.stamp};

    qcmd = '0;

    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          if (!in_if.mode) begin
            need_nxt  = in_if.needed_time;
            scan_nxt  = '0;
            state_nxt = ST_SCAN;
          end else if (any_queued) begin
            lv_nxt    = lv_pick;
            slice_nxt = SLICE_W'(base_r) << lv_pick;
            state_nxt = ST_DPOP;
          end else begin
            // nothing queued: idle result, clock untouched
            res_nxt        = '0;
            res_nxt.status = mfq_pkg::STAT_IDLE;
            state_nxt      = ST_OUT;
          end
        end
      end

      ST_SCAN: begin
        if (chunk_found) begin
          busy_nxt[free_slot] = 1'b1;
          job_we    = 1'b1;
          job_waddr = free_slot;
          job_wdata = '{needed: need_r, used: '0, stamp: elapsed_r};
          qcmd.push      = 1'b1;
          qcmd.push_lv   = '0;
          qcmd.push_slot = mfq_pkg::SLOT_MAX_W'(free_slot);
          res_nxt          = '0;
          res_nxt.status   = mfq_pkg::STAT_ACCEPTED;
          res_nxt.job_slot = mfq_pkg::JOB_SLOT_W'(free_slot);
          state_nxt        = ST_OUT;
        end else if (scan_last) begin
          res_nxt        = '0;
          res_nxt.status = mfq_pkg::STAT_REJECTED;
          state_nxt      = ST_OUT;
        end else begin
          scan_nxt = scan_r + CH_W'(1);
        end
      end

      ST_DPOP: begin
        qcmd.pop    = 1'b1;
        qcmd.pop_lv = mfq_pkg::LV_MAX_W'(lv_r);
        state_nxt   = ST_DJRD;
      end

      ST_DJRD: begin
        job_re                = 1'b1;
        job_raddr             = q_rd_slot;
        slot_nxt              = q_rd_slot;
        res_nxt               = '0;
        res_nxt.job_slot      = mfq_pkg::JOB_SLOT_W'(q_rd_slot);
        res_nxt.run_level     = mfq_pkg::LEVEL_OUT_W'(lv_r);
        res_nxt.granted_slice = mfq_pkg::GRANT_W'(slice_r);
        state_nxt             = ST_DUSED;
      end

      ST_DUSED: begin
        alu_a     = CW'(job_rd_r.used);
        alu_b     = CW'(slice_r);
        used_nxt  = used_sum;
        state_nxt = ST_DCLK;
      end

      ST_DCLK: begin
        alu_a       = elapsed_r;
        alu_b       = CW'(slice_r);
        elapsed_nxt = alu_res[CW-1:0];
        state_nxt   = ST_DCMP;
      end

      ST_DCMP: begin
        // no carry out of used - needed means still unfinished
        alu_a   = CW'(used_r);
        alu_b   = CW'(job_rd_r.needed);
        alu_sub = 1'b1;
        job_we  = 1'b1;
        if (alu_res[CW]) begin
          busy_nxt[slot_r] = 1'b0;
          res_nxt.status   = mfq_pkg::STAT_FINISHED;
          state_nxt        = ST_DSUB1;
        end else if (lv_r != LV_W'(LEVELS - 1)) begin
          qcmd.push          = 1'b1;
          qcmd.push_lv       = mfq_pkg::LV_MAX_W'(lv_r + LV_W'(1));
          qcmd.push_slot     = mfq_pkg::SLOT_MAX_W'(slot_r);
          res_nxt.status     = mfq_pkg::STAT_DEMOTED;
          res_nxt.next_level = mfq_pkg::LEVEL_OUT_W'(lv_r) + mfq_pkg::LEVEL_OUT_W'(1);
          state_nxt          = ST_OUT;
        end else begin
          busy_nxt[slot_r] = 1'b0;
          res_nxt.status   = mfq_pkg::STAT_RETIRED;
          state_nxt        = ST_OUT;
        end
      end

      ST_DSUB1: begin
        alu_a             = elapsed_r;
        alu_b             = job_rd_r.stamp;
        alu_sub           = 1'b1;
        res_nxt.wait_time = alu_res[CW-1:0];
        state_nxt         = ST_DSUB2;
      end

      ST_DSUB2: begin
        alu_a             = res_r.wait_time;
        alu_b             = CW'(used_r);
        alu_sub           = 1'b1;
        res_nxt.wait_time = alu_res[CW-1:0];
        state_nxt         = ST_OUT;
      end

      ST_OUT: begin
        if (out_free) begin
          out_pay_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= mfq_pkg::BASE_RESET;
      busy_r      <= '0;
      elapsed_r   <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      busy_r      <= busy_nxt;
      elapsed_r   <= elapsed_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    need_r    <= need_nxt;
    lv_r      <= lv_nxt;
    slot_r    <= slot_nxt;
    slice_r   <= slice_nxt;
    used_r    <= used_nxt;
    res_r     <= res_nxt;
    out_pay_r <= out_pay_nxt;
  end

  always_ff @(posedge clk) begin
    if (job_we) begin
      job_mem[job_waddr] <= job_wdata;
    end
    if (job_re) begin
      job_rd_r <= job_mem[job_raddr];
    end
  end

  assign in_if.ready          = (state_r == ST_IDLE);
  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_pay_r.status;
  assign out_if.job_slot      = out_pay_r.job_slot;
  assign out_if.run_level     = out_pay_r.run_level;
  assign out_if.granted_slice = out_pay_r.granted_slice;
  assign out_if.next_level    = out_pay_r.next_level;
  assign out_if.wait_time     = out_pay_r.wait_time;

  // the clock only moves in the step that charges the slice
  a_clk_moves_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DCLK) |=> $stable(elapsed_r))
    else $error("elapsed clock changed outside the charge step");

  // an idle dispatch reports nothing but its status
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status == mfq_pkg::STAT_IDLE)) |->
    (out_if.job_slot == '0) && (out_if.granted_slice == '0) && (out_if.wait_time == '0))
    else $error("idle result carries nonzero fields");

  // a demoted job lands one level below where it ran
  a_demote_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status == mfq_pkg::STAT_DEMOTED)) |->
    (out_if.next_level == out_if.run_level + mfq_pkg::LEVEL_OUT_W'(1)))
    else $error("demoted job reports wrong next level");

  // a rejected arrival only when every slot is busy
  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && scan_last && !chunk_found) |-> (&busy_r))
    else $error("arrival rejected with a free slot");

endmodule

[sim/testbench.sv]
// self-checking testbench of the multilevel feedback queue scheduler unit
module testbench;

  // cycles with no handshake on either channel before the run is abandoned;
  // the worst legal quiet stretch is the forced result hold-off plus one item
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  // wait after the last owed result, ample to catch stray results
  localparam int DRAIN_CYCLES = 20;

  localparam logic MODE_ARRIVE   = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [mfq_pkg::BASE_W-1:0] cfg_wdata;

  mfq_in_if  in_ch ();
  mfq_out_if out_ch ();

  multilevel_feedback_queue_scheduler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // scheduler state as the testbench tracks it
  logic [mfq_pkg::BASE_W-1:0]    slice_base;
  logic [mfq_pkg::NEED_W-1:0]    job_need    [mfq_pkg::SLOTS_DEF];
  logic [mfq_pkg::NEED_W-1:0]    job_run     [mfq_pkg::SLOTS_DEF];
  logic [mfq_pkg::CLK_W-1:0]     job_arrival [mfq_pkg::SLOTS_DEF];
  logic [mfq_pkg::SLOTS_DEF-1:0] slot_taken;
  int unsigned                   level_queue [mfq_pkg::LEVELS_DEF][$];
  logic [mfq_pkg::CLK_W-1:0]     sched_clock;

  // results owed by the block, oldest first
  mfq_pkg::result_t results_due [$];

  int mismatches  = 0;
  int idle_cycles = 0;

  // idling controls shared by the sender, the receiver and the tests
  bit tx_quiet    = 1'b0;
  bit rx_quiet    = 1'b0;
  bit rx_hold_req = 1'b0;

  function automatic void clear_schedule();
    slice_base  = mfq_pkg::BASE_RESET;
    slot_taken  = '0;
    sched_clock = '0;
    foreach (level_queue[l]) level_queue[l].delete();
  endfunction

  // works out the result of one item and advances the tracked state
  function automatic mfq_pkg::result_t schedule_item(logic mode,
                                                     logic [mfq_pkg::NEED_W-1:0] need);
    mfq_pkg::result_t          r;
    int                        lv;
    int unsigned               slot;
    logic [mfq_pkg::CLK_W-1:0] slice;
    logic [mfq_pkg::CLK_W-1:0] used;
    r = '0;
    if (mode == MODE_ARRIVE) begin
      // lowest free slot wins, full table rejects
      r.status = mfq_pkg::STAT_REJECTED;
      for (int s = 0; s < mfq_pkg::SLOTS_DEF; s++) begin
        if (!slot_taken[s]) begin
          slot_taken[s]  = 1'b1;
          job_need[s]    = need;
          job_run[s]     = '0;
          job_arrival[s] = sched_clock;
          level_queue[0].push_back(s);
          r.status   = mfq_pkg::STAT_ACCEPTED;
          r.job_slot = mfq_pkg::JOB_SLOT_W'(s);
          break;
        end
      end
      return r;
    end
    // dispatch: head of the lowest non-empty level
    r.status = mfq_pkg::STAT_IDLE;
    lv = 0;
    while (lv < mfq_pkg::LEVELS_DEF && level_queue[lv].size() == 0) lv++;
    if (lv == mfq_pkg::LEVELS_DEF) return r;
    slot  = level_queue[lv].pop_front();
    slice = mfq_pkg::CLK_W'(slice_base) << lv;
    used  = mfq_pkg::CLK_W'(job_run[slot]) + slice;
    if (used > 32'h0000_FFFF) used = 32'h0000_FFFF;
    job_run[slot] = used[mfq_pkg::NEED_W-1:0];
    sched_clock   = sched_clock + slice;
    r.job_slot      = mfq_pkg::JOB_SLOT_W'(slot);
    r.run_level     = mfq_pkg::LEVEL_OUT_W'(lv);
    r.granted_slice = slice[mfq_pkg::GRANT_W-1:0];
    if (used < mfq_pkg::CLK_W'(job_need[slot])) begin
      if (lv + 1 < mfq_pkg::LEVELS_DEF) begin
        level_queue[lv + 1].push_back(slot);
        r.status     = mfq_pkg::STAT_DEMOTED;
        r.next_level = mfq_pkg::LEVEL_OUT_W'(lv + 1);
      end else begin
        // unfinished at the last level: dropped, no wait reported
        slot_taken[slot] = 1'b0;
        r.status         = mfq_pkg::STAT_RETIRED;
      end
    end else begin
      slot_taken[slot] = 1'b0;
      r.status         = mfq_pkg::STAT_FINISHED;
      r.wait_time      = sched_clock - job_arrival[slot] - used;
    end
    return r;
  endfunction

  // mostly back to back, sometimes a few cycles, rarely a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // needed time scaled to the current slice so jobs end on every level
  function automatic logic [mfq_pkg::NEED_W-1:0] pick_need();
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 9);
    if (r < 6) v = $urandom_range(1, 4 * int'(slice_base));
    else if (r < 8) v = $urandom_range(1, 40 * int'(slice_base));
    else v = $urandom_range(1, 65535);
    if (v > 65535) v = 65535;
    return mfq_pkg::NEED_W'(v);
  endfunction

  function automatic string show(mfq_pkg::result_t r);
    return $sformatf("status %0d slot %0d level %0d slice %0d next %0d wait %0d",
                     r.status, r.job_slot, r.run_level, r.granted_slice,
                     r.next_level, r.wait_time);
  endfunction

  // offers one item, returns at the edge where it is taken
  task automatic send_item(input logic mode, input logic [mfq_pkg::NEED_W-1:0] need);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // valid stays high from a previous item when there is no gap
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.needed_time <= need;
    do @(posedge clk); while (!in_ch.ready);
    results_due.push_back(schedule_item(mode, need));
  endtask

  // arrival odds follow the table fill so it swings between empty and full
  task automatic send_random_item();
    int jobs;
    int odds;
    jobs = $countones(slot_taken);
    odds = (jobs < 8) ? 65 : (jobs < 24) ? 50 : 35;
    if ($urandom_range(0, 99) < odds) send_item(MODE_ARRIVE, pick_need());
    else send_item(MODE_DISPATCH, mfq_pkg::NEED_W'($urandom_range(0, 65535)));
  endtask

  // stop offering and wait until every owed result is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_base(input logic [mfq_pkg::BASE_W-1:0] value);
    settle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we     <= 1'b0;
    slice_base  = value;
  endtask

  // dispatch until every job is gone, then once more on the empty table
  task automatic drain_jobs();
    while (slot_taken != '0) begin
      send_item(MODE_DISPATCH, mfq_pkg::NEED_W'($urandom_range(0, 65535)));
    end
    send_item(MODE_DISPATCH, mfq_pkg::NEED_W'($urandom_range(0, 65535)));
  endtask

  // idle dispatch, acceptance, demotion down all levels, finish with a wait,
  // needed-time extremes
  task automatic test_lifecycle();
    send_item(MODE_DISPATCH, '1);
    send_item(MODE_ARRIVE, 16'd1);
    send_item(MODE_ARRIVE, 16'hFFFF);
    send_item(MODE_ARRIVE, 16'd25);
    send_item(MODE_ARRIVE, 16'h5555);
    send_item(MODE_ARRIVE, 16'hAAAA);
    repeat (13) send_item(MODE_DISPATCH, '0);
  endtask

  // smallest slice; fill every free slot, then the arrivals left over bounce off
  task automatic test_table_full();
    write_base(10'd1);
    repeat (mfq_pkg::SLOTS_DEF + 2) begin
      send_item(MODE_ARRIVE, mfq_pkg::NEED_W'($urandom_range(1, 8)));
    end
    drain_jobs();
  endtask

  task automatic test_random_mix(input logic [mfq_pkg::BASE_W-1:0] base, input int count);
    write_base(base);
    repeat (count) send_random_item();
    drain_jobs();
  endtask

  // the receiver holds off for a long stretch while items keep coming,
  // so the output register fills and the input stalls
  task automatic test_backpressure();
    rx_hold_req = 1'b1;
    tx_quiet    = 1'b1;
    repeat (24) send_random_item();
    tx_quiet = 1'b0;
  endtask

  // full rate on both sides
  task automatic test_no_idling();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (40) send_random_item();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // result side: random stalls plus the forced hold-off
  initial begin : result_sink
    int   stall_left;
    int   hold_left;
    logic take;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        hold_left   = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else begin
        take = 1'b1;
        if (!rx_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      out_ch.ready <= take;
    end
  end

  // every taken result against the oldest one owed
  always @(posedge clk) begin : result_check
    mfq_pkg::result_t seen;
    mfq_pkg::result_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.status        = mfq_pkg::status_t'(out_ch.status);
      seen.job_slot      = out_ch.job_slot;
      seen.run_level     = out_ch.run_level;
      seen.granted_slice = out_ch.granted_slice;
      seen.next_level    = out_ch.next_level;
      seen.wait_time     = out_ch.wait_time;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no item owed: %s", show(seen));
      end else begin
        due = results_due.pop_front();
        // all six fields at once, x or z counts as a mismatch
        if (seen !== due) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch expected %s", show(due));
            $display("         actual   %s", show(seen));
          end
        end
      end
    end
  end

  // a hang shows up as a long run of cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("multilevel_feedback_queue_scheduler_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_ARRIVE;
    in_ch.needed_time = '0;
    clear_schedule();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset slice first, then both extremes and a few in between
    test_lifecycle();
    test_table_full();
    test_random_mix(10'd1023, 50);
    test_backpressure();
    test_random_mix(mfq_pkg::BASE_W'($urandom_range(2, 20)), 50);
    test_no_idling();
    test_random_mix(mfq_pkg::BASE_W'($urandom_range(1, 1023)), 50);
    test_random_mix(mfq_pkg::BASE_RESET, 50);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("multilevel_feedback_queue_scheduler_unit verification clean");
    end else begin
      $display("multilevel_feedback_queue_scheduler_unit verification failed");
    end
    $finish;
  end

endmodule
